>>> hdl/kwm_pkg.sv
// Shared types and constants for the k-way sorted merge block.
package kwm_pkg;

   localparam int NUM_LISTS_DEF  = 8;
   localparam int LIST_DEPTH_DEF = 16;

   localparam int VALUE_W  = 32;
   localparam int SEL_W    = 3;
   localparam int CSR_W    = 4;
   localparam int STATUS_W = 2;

   localparam logic [CSR_W-1:0] CSR_RESET = 4'd8;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_UNUSED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_DONE
   } eng_state_type;

   // One queued word, already classified by the front end.
   typedef struct packed {
      op_type                     op;
      logic                       unused;
      logic [SEL_W-1:0]           sel;
      logic signed [VALUE_W-1:0]  value;
   } item_type;

endpackage

>>> hdl/kwm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module kwm_ram
   import kwm_pkg::*;
#(
   parameter int WIDTH = VALUE_W,
   parameter int DEPTH = NUM_LISTS_DEF * LIST_DEPTH_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/kwm_front.sv
// Front end: accepts request words, flags pushes to unused lists, queues them.
module kwm_front
   import kwm_pkg::*;
#(
   parameter int NUM_LISTS = NUM_LISTS_DEF,
   localparam int CNT_W    = $clog2(NUM_LISTS + 1),
   localparam int CMP_W    = (CNT_W > SEL_W) ? CNT_W : SEL_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_operation,
   input  logic [SEL_W-1:0]           req_list_select,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [CNT_W-1:0]           active_cnt,
   output logic                       q_valid,
   output item_type                   q_item,
   input  logic                       q_take
);

   item_type   q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       push_q;

   always_comb begin
      new_item.op     = op_type'(req_operation);
      new_item.sel    = req_list_select;
      new_item.value  = req_value;
      new_item.unused = (CMP_W'(req_list_select) >= CMP_W'(active_cnt));
   end

   assign req_stall = (count_ff == 2'd2);
   assign push_q    = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_q) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (q_take) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      priority if (push_q && !q_take) begin
         count_in = count_ff + 2'd1;
      end else if (q_take && !push_q) begin
         count_in = count_ff - 2'd1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> hdl/kwm_engine.sv
// Back end: list storage, pointer state, head scan for pops and the response register.
module kwm_engine
   import kwm_pkg::*;
#(
   parameter int NUM_LISTS  = NUM_LISTS_DEF,
   parameter int LIST_DEPTH = LIST_DEPTH_DEF,
   localparam int CNT_W     = $clog2(NUM_LISTS + 1),
   localparam int LW        = $clog2(NUM_LISTS),
   localparam int PW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
   localparam int FW        = $clog2(LIST_DEPTH + 1),
   localparam int DEPTH     = NUM_LISTS * LIST_DEPTH,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [CNT_W-1:0]           active_cnt,
   input  logic                       q_valid,
   input  item_type                   q_item,
   output logic                       q_take,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [VALUE_W-1:0]  rsp_out_value,
   output logic [SEL_W-1:0]           rsp_out_list,
   output logic [STATUS_W-1:0]        rsp_status
);

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == PW'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] list,
                                              input logic [PW-1:0] ptr);
      return AW'(list) * AW'(LIST_DEPTH) + AW'(ptr);
   endfunction

   function automatic logic [SEL_W-1:0] list_to_sel(input logic [LW-1:0] list);
      logic [LW+SEL_W-1:0] w;
      w = {{SEL_W{1'b0}}, list};
      return w[SEL_W-1:0];
   endfunction

   function automatic logic [LW-1:0] sel_to_list(input logic [SEL_W-1:0] sel);
      logic [LW+SEL_W-1:0] w;
      w = {{LW{1'b0}}, sel};
      return w[LW-1:0];
   endfunction

   eng_state_type state_ff, state_in;

   logic [PW-1:0] rp_ff   [NUM_LISTS];
   logic [PW-1:0] rp_in   [NUM_LISTS];
   logic [PW-1:0] wp_ff   [NUM_LISTS];
   logic [PW-1:0] wp_in   [NUM_LISTS];
   logic [FW-1:0] fill_ff [NUM_LISTS];
   logic [FW-1:0] fill_in [NUM_LISTS];

   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic                      pend_ff, pend_in;
   logic [LW-1:0]             pend_idx_ff, pend_idx_in;
   logic                      found_ff, found_in;
   logic [LW-1:0]             best_idx_ff, best_idx_in;
   logic signed [VALUE_W-1:0] best_val_ff, best_val_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [SEL_W-1:0]          rsp_list_ff, rsp_list_in;
   status_type                rsp_status_ff, rsp_status_in;

   logic                      out_free;
   logic [LW-1:0]             push_idx;
   logic [LW-1:0]             scan_idx;
   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [AW-1:0]             ram_raddr;
   logic [VALUE_W-1:0]        ram_rdata;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign push_idx = sel_to_list(q_item.sel);
   assign scan_idx = idx_ff[LW-1:0];

   kwm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (q_item.value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_val_in   = best_val_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_list_in   = rsp_list_ff;
      rsp_status_in = rsp_status_ff;
      q_take        = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = addr_of(push_idx, wp_ff[push_idx]);
      ram_raddr     = addr_of(scan_idx, rp_ff[scan_idx]);

      unique case (state_ff)
         ENG_IDLE: begin
            if (q_valid) begin
               if (q_item.op == OP_PUSH) begin
                  if (out_free) begin
                     q_take       = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_list_in  = q_item.sel;
                     priority if (q_item.unused) begin
                        rsp_status_in = ST_UNUSED;
                     end else if (fill_ff[push_idx] == FW'(LIST_DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ram_we            = 1'b1;
                        wp_in[push_idx]   = ptr_next(wp_ff[push_idx]);
                        fill_in[push_idx] = fill_ff[push_idx] + 1'b1;
                        rsp_status_in     = ST_OK;
                     end
                  end
               end else begin
                  q_take   = 1'b1;
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = ENG_SCAN;
               end
            end
         end

         ENG_SCAN: begin
            // Head read for the list issued last cycle is now on the RAM output.
            if (pend_ff) begin
               if (!found_ff || ($signed(ram_rdata) < best_val_ff)) begin
                  found_in    = 1'b1;
                  best_idx_in = pend_idx_ff;
                  best_val_in = $signed(ram_rdata);
               end
            end
            if (idx_ff < active_cnt) begin
               pend_in     = (fill_ff[scan_idx] != '0);
               pend_idx_in = scan_idx;
               idx_in      = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = ENG_DONE;
            end
         end

         ENG_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  rsp_value_in         = best_val_ff;
                  rsp_list_in          = list_to_sel(best_idx_ff);
                  rsp_status_in        = ST_OK;
                  rp_in[best_idx_ff]   = ptr_next(rp_ff[best_idx_ff]);
                  fill_in[best_idx_ff] = fill_ff[best_idx_ff] - 1'b1;
               end else begin
                  rsp_value_in  = '0;
                  rsp_list_in   = '0;
                  rsp_status_in = ST_EMPTY;
               end
               state_in = ENG_IDLE;
            end
         end

         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            rp_ff[i]   <= '0;
            wp_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      best_idx_ff   <= best_idx_in;
      best_val_ff   <= best_val_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_list_ff   <= rsp_list_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_list  = rsp_list_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

>>> hdl/k_way_sorted_merge_top.sv
// K-way sorted merge: a set of bounded list FIFOs and a pop that removes the smallest head.
//
// Request channel (req_): a push word appends req_value to list req_list_select; a pop
// word removes the smallest head among the lists in use, lowest list index on ties.
// Every request word yields exactly one response word (rsp_) with a status code.
// The csr_ port writes the number of lists in use; write it only while the block is idle.
// Requests enter a two-word queue, so req_stall rises only when that queue is full.
// A push word moves from the queue into the response register once that register is free.
// A pop scans the head of each list in use through the single read port of the list
// store, one list per cycle, then holds in a done state until the response register frees.
// Words are executed one at a time; pushes run at one per cycle while the response
// register is free, and no new word is taken until a pop's response is written.
// Reset empties every list, clears the response valid flag and sets all lists in use.
// When the receiver holds rsp_stall, the response word stays stable; a pop behind it may
// still finish its scan, and the two-word queue then fills before req_stall rises.
module k_way_sorted_merge_top
   import kwm_pkg::*;
#(
   parameter int NUM_LISTS  = NUM_LISTS_DEF,
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_operation,
   input  logic [SEL_W-1:0]           req_list_select,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [VALUE_W-1:0]  rsp_out_value,
   output logic [SEL_W-1:0]           rsp_out_list,
   output logic [STATUS_W-1:0]        rsp_status,
   input  logic                       csr_wr_en,
   input  logic [CSR_W-1:0]           csr_wr_data
);

   localparam int CNT_W = $clog2(NUM_LISTS + 1);
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   logic [CSR_W-1:0] csr_lists_ff;
   logic [CMP_W-1:0] active_wide;
   logic [CNT_W-1:0] active_cnt;
   logic             q_valid;
   logic             q_take;
   item_type         q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_lists_ff <= CSR_RESET;
      end else if (csr_wr_en) begin
         csr_lists_ff <= csr_wr_data;
      end
   end

   // A zero count means one list; a count beyond the build saturates.
   always_comb begin
      priority if (csr_lists_ff == '0) begin
         active_wide = CMP_W'(1);
      end else if (CMP_W'(csr_lists_ff) > CMP_W'(NUM_LISTS)) begin
         active_wide = CMP_W'(NUM_LISTS);
      end else begin
         active_wide = CMP_W'(csr_lists_ff);
      end
   end

   assign active_cnt = active_wide[CNT_W-1:0];

   kwm_front #(
      .NUM_LISTS (NUM_LISTS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_list_select (req_list_select),
      .req_value       (req_value),
      .active_cnt      (active_cnt),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_take          (q_take)
   );

   kwm_engine #(
      .NUM_LISTS  (NUM_LISTS),
      .LIST_DEPTH (LIST_DEPTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .active_cnt    (active_cnt),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_take        (q_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_value (rsp_out_value),
      .rsp_out_list  (rsp_out_list),
      .rsp_status    (rsp_status)
   );

endmodule

>>> verif/tb_k_way_sorted_merge_top.sv
// Self-checking testbench for the k-way sorted merge block with a built-in list predictor.
module tb_k_way_sorted_merge_top;
   import kwm_pkg::*;

   localparam int NUM_LISTS     = NUM_LISTS_DEF;
   localparam int LIST_DEPTH    = LIST_DEPTH_DEF;
   localparam int SETTLE_CYCLES = 2 * NUM_LISTS + 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_WORDS   = 105;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [SEL_W-1:0]          list;
      status_type                status;
   } merge_result_type;

   // Keeps its own copy of every list and the register, and queues the response
   // that each accepted word must produce.
   class merge_tracker;
      logic signed [VALUE_W-1:0] list_mem [NUM_LISTS][LIST_DEPTH];
      int               rd_ptr [NUM_LISTS];
      int               wr_ptr [NUM_LISTS];
      int               fill [NUM_LISTS];
      logic [CSR_W-1:0] lists_in_use;
      merge_result_type awaited_results [$];
      int               error_count;
      int               push_count;
      int               pop_count;
      int               status_count [4];

      function new();
         for (int k = 0; k < NUM_LISTS; k++) begin
            rd_ptr[k] = 0;
            wr_ptr[k] = 0;
            fill[k]   = 0;
         end
         for (int s = 0; s < 4; s++) status_count[s] = 0;
         lists_in_use = CSR_RESET;
         error_count  = 0;
         push_count   = 0;
         pop_count    = 0;
      endfunction

      function int active_count();
         if (lists_in_use == 0) return 1;
         if (lists_in_use > NUM_LISTS) return NUM_LISTS;
         return int'(lists_in_use);
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      function void note_request(op_type op, logic [SEL_W-1:0] sel,
                                 logic signed [VALUE_W-1:0] val);
         merge_result_type          r;
         logic signed [VALUE_W-1:0] head;
         logic signed [VALUE_W-1:0] best_val;
         int                        n;
         int                        best;
         bit                        found;
         n        = active_count();
         r.value  = '0;
         r.list   = '0;
         best     = 0;
         best_val = '0;
         found    = 1'b0;
         if (op == OP_PUSH) begin
            push_count++;
            r.list = sel;
            if (int'(sel) >= n) begin
               r.status = ST_UNUSED;
            end else if (fill[sel] >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               list_mem[sel][wr_ptr[sel]] = val;
               wr_ptr[sel] = (wr_ptr[sel] + 1) % LIST_DEPTH;
               fill[sel]++;
               r.status = ST_OK;
            end
         end else begin
            pop_count++;
            for (int k = 0; k < n; k++) begin
               if (fill[k] != 0) begin
                  head = list_mem[k][rd_ptr[k]];
                  // Strict less-than keeps the lowest index on equal heads.
                  if (!found || head < best_val) begin
                     found    = 1'b1;
                     best     = k;
                     best_val = head;
                  end
               end
            end
            if (!found) begin
               r.status = ST_EMPTY;
            end else begin
               r.value      = best_val;
               r.list       = SEL_W'(best);
               rd_ptr[best] = (rd_ptr[best] + 1) % LIST_DEPTH;
               fill[best]--;
               r.status     = ST_OK;
            end
         end
         status_count[int'(r.status)]++;
         awaited_results.insert(awaited_results.size(), r);
      endfunction

      function void check_response(logic signed [VALUE_W-1:0] value,
                                   logic [SEL_W-1:0] list, logic [STATUS_W-1:0] status);
         merge_result_type want;
         if (awaited_results.size() == 0) begin
            $error("Response word arrived with nothing outstanding: value %0d list %0d status %0d",
                   value, list, status);
            error_count++;
            return;
         end
         want = awaited_results.pop_front();
         if (want.value !== value) begin
            $error("out_value mismatch: expected %0d, actual %0d", want.value, value);
            error_count++;
         end
         if (want.list !== list) begin
            $error("out_list mismatch: expected %0d, actual %0d", want.list, list);
            error_count++;
         end
         if (want.status !== status_type'(status)) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            error_count++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_operation;
   logic [SEL_W-1:0]          req_list_select;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic [SEL_W-1:0]          rsp_out_list;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      csr_wr_en;
   logic [CSR_W-1:0]          csr_wr_data;

   merge_tracker tracker;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           words_sent;
   int           csr_writes;
   int           cycle_count;
   longint       last_pushed [NUM_LISTS];

   k_way_sorted_merge_top #(
      .NUM_LISTS  (NUM_LISTS),
      .LIST_DEPTH (LIST_DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_list_select (req_list_select),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_list    (rsp_out_list),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, tracker.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // The receiver decides its stall at each falling edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            tracker.check_response(rsp_out_value, rsp_out_list, rsp_status);
         end
      end
   end

   // Offers one word and returns at the falling edge after it was accepted.
   task automatic send_word(input op_type op, input logic [SEL_W-1:0] sel,
                            input logic signed [VALUE_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_operation   = op;
      req_list_select = sel;
      req_value       = val;
      do @(posedge clock); while (req_stall);
      tracker.note_request(op, sel, val);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   // The block must be idle before the register changes.
   task automatic write_lists_in_use(input logic [CSR_W-1:0] count);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = count;
      @(negedge clock);
      csr_wr_en = 1'b0;
      tracker.lists_in_use = count;
      csr_writes++;
   endtask

   // Next value for a list that keeps it ascending; a drained list starts over anywhere.
   function automatic logic signed [VALUE_W-1:0] next_value(input int k);
      longint step;
      if (tracker.fill[k] == 0) begin
         last_pushed[k] = longint'($signed($urandom));
      end else begin
         step = longint'($urandom_range(0, 1 << $urandom_range(0, 24)));
         last_pushed[k] = last_pushed[k] + step;
         if (last_pushed[k] > 64'sd2147483647) last_pushed[k] = 64'sd2147483647;
      end
      return VALUE_W'(last_pushed[k]);
   endfunction

   initial begin
      logic [CSR_W-1:0] phase_setting [6];
      int               phase_end;
      int               n;
      int               k;
      int               count;
      int               pick;
      bit               drained;

      phase_setting = '{4'd8, 4'd3, 4'd1, 4'd12, 4'd0, 4'd6};
      tracker         = new();
      words_sent      = 0;
      csr_writes      = 0;
      send_idle_pct   = 23;
      recv_idle_pct   = 68;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = 1'b0;
      req_list_select = '0;
      req_value       = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      for (int i = 0; i < NUM_LISTS; i++) last_pushed[i] = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty pop, extreme values, ties on equal heads, unsorted input.
      send_word(OP_POP, 3'd0, 32'sd0);
      send_word(OP_PUSH, 3'd0, 32'sh8000_0000);
      send_word(OP_PUSH, 3'd7, 32'sh7fff_ffff);
      send_word(OP_PUSH, 3'd3, 32'sd0);
      send_word(OP_PUSH, 3'd1, -32'sd1);
      send_word(OP_PUSH, 3'd2, 32'sd0);
      send_word(OP_PUSH, 3'd4, -32'sd1);
      repeat (5) send_word(OP_POP, 3'd0, 32'sd0);
      send_word(OP_PUSH, 3'd6, 32'sd5);
      send_word(OP_PUSH, 3'd6, 32'sd3);
      repeat (4) send_word(OP_POP, 3'd7, 32'sd0);

      // A lowered register refuses pushes above it and hides lists that still hold data.
      write_lists_in_use(4'd2);
      send_word(OP_PUSH, 3'd5, 32'sd9);
      send_word(OP_PUSH, 3'd1, 32'sd7);
      write_lists_in_use(4'd0);
      send_word(OP_PUSH, 3'd1, 32'sd8);
      send_word(OP_PUSH, 3'd0, -32'sd5);
      send_word(OP_POP, 3'd0, 32'sd0);
      write_lists_in_use(4'd15);
      send_word(OP_POP, 3'd0, 32'sd0);

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 68;
            recv_idle_pct = 23;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_lists_in_use(phase_setting[phase]);
         phase_end = words_sent + PHASE_WORDS;
         drained   = 1'b0;
         while (words_sent < phase_end) begin
            n    = tracker.active_count();
            pick = $urandom_range(99);
            if (pick < 45) begin
               // Sorted pushes spread over the lists in use, then a run of pops.
               count = $urandom_range(2, 12);
               repeat (count) begin
                  k = $urandom_range(0, n - 1);
                  send_word(OP_PUSH, SEL_W'(k), next_value(k));
               end
               repeat ($urandom_range(1, count + 2)) send_word(OP_POP, SEL_W'($urandom), 32'sd0);
            end else if (pick < 55) begin
               // Fill one list past its depth to reach the full status.
               k     = $urandom_range(0, n - 1);
               count = LIST_DEPTH - tracker.fill[k] + $urandom_range(1, 2);
               repeat (count) send_word(OP_PUSH, SEL_W'(k), next_value(k));
            end else if (pick < 78) begin
               repeat ($urandom_range(1, 6)) send_word(OP_POP, SEL_W'($urandom), 32'sd0);
            end else begin
               send_word(op_type'($urandom_range(0, 1)), SEL_W'($urandom), $signed($urandom));
            end
            if (!drained && words_sent > phase_end - PHASE_WORDS / 2) begin
               wait_drained();
               drained = 1'b1;
            end
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Run covered %0d words (%0d pushes, %0d pops) across %0d register writes.",
               words_sent, tracker.push_count, tracker.pop_count, csr_writes);
      $display("Statuses produced: %0d ok, %0d full, %0d empty, %0d list not in use.",
               tracker.status_count[ST_OK], tracker.status_count[ST_FULL],
               tracker.status_count[ST_EMPTY], tracker.status_count[ST_UNUSED]);
      if (tracker.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/kwm_pkg.sv
hdl/kwm_ram.sv
hdl/kwm_front.sv
hdl/kwm_engine.sv
hdl/k_way_sorted_merge_top.sv
verif/tb_k_way_sorted_merge_top.sv
